// File: design/fcmc_pkg.sv
package fcmc_pkg;

	localparam int KEY_IN_W = 16;
	localparam int MISS_W   = 16;
	localparam int CAP_W    = 8;

	localparam logic [MISS_W-1:0] MISS_MAX = '1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_CHECK,
		ST_FIN
	} fcmc_state_t;

	typedef struct packed {
		logic [KEY_IN_W-1:0] key;
		logic                sequence_end;
	} fcmc_req_t;

	typedef struct packed {
		logic              hit;
		logic [MISS_W-1:0] miss_total;
		logic              end_echo;
	} fcmc_res_t;

endpackage

// File: design/fcmc_if.sv
interface fcmc_req_if;
	logic                         valid;
	logic                         ready;
	logic [fcmc_pkg::KEY_IN_W-1:0] key;
	logic                         sequence_end;

	modport source (output valid, key, sequence_end, input ready);
	modport sink (input valid, key, sequence_end, output ready);
endinterface

interface fcmc_rsp_if;
	logic                        valid;
	logic                        ready;
	logic                        hit;
	logic [fcmc_pkg::MISS_W-1:0] miss_total;
	logic                        end_echo;

	modport source (output valid, hit, miss_total, end_echo, input ready);
	modport sink (input valid, hit, miss_total, end_echo, output ready);
endinterface

interface fcmc_cfg_if;
	logic                       valid;
	logic                       ready;
	logic [fcmc_pkg::CAP_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

// File: design/fcmc_ram.sv
module fcmc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 128
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: design/fcmc_ctrl.sv
module fcmc_ctrl #(
	parameter int MAX_ENTRIES = 128,
	parameter int KEY_WIDTH   = 16,
	parameter int CAPW        = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  fcmc_pkg::fcmc_req_t req,
	input  logic [CAPW-1:0]     cap,
	output logic                res_valid,
	input  logic                res_ready,
	output fcmc_pkg::fcmc_res_t res,
	output logic                busy
);

	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

	fcmc_pkg::fcmc_state_t state_q, state_nx;

	logic [CW-1:0]                   fill_q;
	logic [AW-1:0]                   ptr_q;
	logic [fcmc_pkg::MISS_W-1:0]     miss_q;
	logic [CW-1:0]                   idx_q;
	logic [CW-1:0]                   lim_q;
	logic [KEY_WIDTH-1:0]            key_q;
	logic                            end_q;
	logic                            hit_q;
	logic                            rd_vld_s1;
	logic [KEY_WIDTH-1:0]            rdata;

	logic [CW-1:0]               active;
	logic [CW-1:0]               lim_c;
	logic                        full;
	logic [AW-1:0]               slot;
	logic [CW-1:0]               slot_inc;
	logic [AW-1:0]               ptr_nx;
	logic [fcmc_pkg::MISS_W-1:0] miss_nx;
	logic                        rd_en;
	logic                        take;
	logic                        done;
	logic                        wr_en;

	// clamp of the capacity register to 1..MAX_ENTRIES
	always_comb begin
		if (cap == '0) begin
			active = CW'(1);
		end else if (cap > CAPW'(MAX_ENTRIES)) begin
			active = CW'(MAX_ENTRIES);
		end else begin
			active = CW'(cap);
		end
	end

	// entries below fill_q are the valid ones
	assign lim_c = (fill_q < active) ? fill_q : active;
	assign full  = (fill_q >= active);

	always_comb begin
		if (!full) begin
			slot = fill_q[AW-1:0];
		end else if (CW'(ptr_q) < active) begin
			slot = ptr_q;
		end else begin
			slot = '0;
		end
		slot_inc = CW'(slot) + CW'(1);
		ptr_nx   = (slot_inc >= active) ? '0 : slot_inc[AW-1:0];
	end

	always_comb begin
		if (hit_q || miss_q == fcmc_pkg::MISS_MAX) begin
			miss_nx = miss_q;
		end else begin
			miss_nx = miss_q + fcmc_pkg::MISS_W'(1);
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			fcmc_pkg::ST_IDLE: begin
				if (req_valid) begin
					state_nx = (lim_c == '0) ? fcmc_pkg::ST_FIN : fcmc_pkg::ST_SCAN;
				end
			end
			fcmc_pkg::ST_SCAN: begin
				if (idx_q + CW'(1) == lim_q) begin
					state_nx = fcmc_pkg::ST_CHECK;
				end
			end
			fcmc_pkg::ST_CHECK: begin
				state_nx = fcmc_pkg::ST_FIN;
			end
			fcmc_pkg::ST_FIN: begin
				if (res_ready) begin
					state_nx = fcmc_pkg::ST_IDLE;
				end
			end
			default: state_nx = fcmc_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		req_ready = (state_q == fcmc_pkg::ST_IDLE);
		rd_en     = (state_q == fcmc_pkg::ST_SCAN);
		res_valid = (state_q == fcmc_pkg::ST_FIN);
		busy      = (state_q != fcmc_pkg::ST_IDLE);
	end

	assign take  = req_valid && req_ready;
	assign done  = res_valid && res_ready;
	assign wr_en = done && !hit_q;

	assign res.hit        = hit_q;
	assign res.miss_total = miss_nx;
	assign res.end_echo   = end_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= fcmc_pkg::ST_IDLE;
			fill_q    <= '0;
			ptr_q     <= '0;
			miss_q    <= '0;
			idx_q     <= '0;
			hit_q     <= 1'b0;
			rd_vld_s1 <= 1'b0;
		end else begin
			state_q   <= state_nx;
			rd_vld_s1 <= rd_en;
			if (take) begin
				idx_q <= '0;
				hit_q <= 1'b0;
			end else begin
				if (rd_en) begin
					idx_q <= idx_q + CW'(1);
				end
				if (rd_vld_s1 && rdata == key_q) begin
					hit_q <= 1'b1;
				end
			end
			if (done) begin
				if (end_q) begin
					fill_q <= '0;
					ptr_q  <= '0;
					miss_q <= '0;
				end else begin
					miss_q <= miss_nx;
					if (!hit_q) begin
						if (full) begin
							ptr_q <= ptr_nx;
						end else begin
							fill_q <= fill_q + CW'(1);
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			key_q <= KEY_WIDTH'(req.key);
			end_q <= req.sequence_end;
			lim_q <= lim_c;
		end
	end

	fcmc_ram #(
		.WIDTH (KEY_WIDTH),
		.DEPTH (MAX_ENTRIES)
	) u_keys (
		.clk   (clk),
		.we    (wr_en),
		.waddr (slot),
		.wdata (key_q),
		.re    (rd_en),
		.raddr (idx_q[AW-1:0]),
		.rdata (rdata)
	);

endmodule

// File: design/fifo_cache_miss_counter.sv
// channel  dir  payload                          beat when
// req      in   key, sequence_end                req.valid & req.ready
// rsp      out  hit, miss_total, end_echo        rsp.valid & rsp.ready
// cfg      in   data (capacity)                  cfg.valid & cfg.ready
//
// one item is looked up at a time: the key store gives one ram read per cycle,
// so the lookup walks the filled entries in order, no more than the capacity,
// and skips the walk while nothing is filled
// reset clears fill count, replacement pointer and miss total; capacity
// returns to MAX_ENTRIES; stored keys need no clearing
// a result sits in the output register while the next item is looked up
module fifo_cache_miss_counter #(
	parameter int MAX_ENTRIES = 128,
	parameter int KEY_WIDTH   = 16
) (
	input logic       clk,
	input logic       arst_n,
	fcmc_req_if.sink  req,
	fcmc_rsp_if.source rsp,
	fcmc_cfg_if.sink  cfg
);

	localparam int CW   = $clog2(MAX_ENTRIES + 1);
	localparam int CAPW = (CW > fcmc_pkg::CAP_W) ? CW : fcmc_pkg::CAP_W;

	logic [CAPW-1:0]     cap_q;
	fcmc_pkg::fcmc_req_t req_pl;
	fcmc_pkg::fcmc_res_t res;
	fcmc_pkg::fcmc_res_t out_q;
	logic                out_vld_q;
	logic                res_valid;
	logic                res_ready;
	logic                busy;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAPW'(MAX_ENTRIES);
		end else if (cfg.valid) begin
			cap_q <= CAPW'(cfg.data);
		end
	end

	assign req_pl.key          = req.key;
	assign req_pl.sequence_end = req.sequence_end;

	fcmc_ctrl #(
		.MAX_ENTRIES (MAX_ENTRIES),
		.KEY_WIDTH   (KEY_WIDTH),
		.CAPW        (CAPW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.req       (req_pl),
		.cap       (cap_q),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.busy      (busy)
	);

	// output register
	assign res_ready = !out_vld_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (res_ready) begin
			out_vld_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign rsp.valid      = out_vld_q;
	assign rsp.hit        = out_q.hit;
	assign rsp.miss_total = out_q.miss_total;
	assign rsp.end_echo   = out_q.end_echo;

	a_res_into_free: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res))
		else $error("result changed while output register full");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> busy)
		else $error("lookup did not start after accepted beat");

	a_miss_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.hit |-> res.miss_total != '0)
		else $error("miss reported with zero miss total");

	a_idle_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |-> !res_valid)
		else $error("result raised while idle");

endmodule
